### src/tsof_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsof_pkg
// types, constants and helpers shared by the syn fingerprinter modules
// ----------------------------------------------------------------------------
package tsof_pkg;

	localparam int TableEntries = 8;
	localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
	localparam int CntW = $clog2(TableEntries + 1);

	localparam logic [1:0] ST_RECORDED = 2'd0;
	localparam logic [1:0] ST_IGNORED  = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	localparam logic [1:0] PH_KIND = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	localparam logic [7:0] OPT_END   = 8'd0;
	localparam logic [7:0] OPT_NOP   = 8'd1;
	localparam logic [7:0] OPT_MSS   = 8'd2;
	localparam logic [7:0] OPT_SCALE = 8'd3;
	localparam logic [7:0] OPT_SACK  = 8'd4;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] host_address;
		logic [2:0]  entry_index;
		logic        new_entry;
		logic [3:0]  os_class;
		logic [7:0]  seen_ttl;
		logic [15:0] window_size;
		logic [15:0] max_segment;
		logic [7:0]  window_scale;
		logic        sack_permitted;
	} out_item_t;

	typedef enum logic [1:0] {
		S_STREAM,
		S_SEARCH,
		S_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic take_byte;
		logic start_search;
		logic search_step;
		logic commit;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic search_done;
	} dp_sts_t;

	function automatic logic [3:0] guess_class(input logic [7:0] ttl,
		input logic [15:0] win, input logic [15:0] mss, input logic [7:0] scl,
		input logic sack);
		logic [3:0] c;
		if (ttl > 8'd128) c = 4'd8;
		else if (ttl > 8'd64) begin
			if (win == 16'd65535 || win == 16'd8192) c = 4'd0;
			else if (win == 16'd64240) c = 4'd1;
			else c = 4'd2;
		end else if (mss == 16'd1460 && (scl == 8'd6 || scl == 8'd7)) c = 4'd3;
		else if (mss == 16'd1460 && sack) c = 4'd4;
		else if (mss == 16'd1460) c = 4'd5;
		else if (mss == 16'd536) c = 4'd6;
		else c = 4'd7;
		return c;
	endfunction

endpackage
`default_nettype wire

### src/tsof_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsof_ctrl
// controller: byte streaming, per-frame table search, result hand-off
// ----------------------------------------------------------------------------
module tsof_ctrl
	import tsof_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_fire,
	input  wire logic    in_last,
	input  wire logic    out_free,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd,
	output logic         in_ready
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_STREAM;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_STREAM: if (in_fire && in_last) state_d = S_SEARCH;
			S_SEARCH: if (sts.search_done) state_d = S_OUT;
			S_OUT:    if (out_free) state_d = S_STREAM;
			default:  state_d = S_STREAM;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_STREAM: begin
				in_ready = 1'b1;
				cmd.take_byte = in_fire;
				cmd.start_search = in_fire && in_last;
			end
			S_SEARCH: cmd.search_step = !sts.search_done;
			S_OUT: begin
				cmd.commit = out_free;
				cmd.load_out = out_free;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

### src/tsof_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsof_datapath
// header parser, option walker, host table and result register
// ----------------------------------------------------------------------------
module tsof_datapath
	import tsof_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire dp_cmd_t cmd,
	input  wire logic [7:0] frame_byte,
	input  wire logic [31:0] own_address,
	input  wire logic    out_taken,
	output dp_sts_t      sts,
	output out_item_t    out_item,
	output logic         out_valid
);

	logic [7:0]  pos_q;
	logic [15:0] ether_q;
	logic [5:0]  iphl_q;
	logic [7:0]  proto_q;
	logic [31:0] src_q;
	logic [7:0]  ttl_q;
	logic [6:0]  tcphl_q;
	logic [7:0]  flags_q;
	logic [15:0] win_q;
	logic [1:0]  ph_q;
	logic [7:0]  kind_q;
	logic [7:0]  left_q;
	logic [15:0] mss_q;
	logic [7:0]  scl_q;
	logic        sack_q;

	logic [TableEntries-1:0] valid_q;
	logic [31:0] addr_q [TableEntries];
	logic [CntW-1:0] sidx_q;
	logic found_q, have_free_q;
	logic [IdxW-1:0] slot_q, free_q;
	logic ign_q;
	logic [3:0] cls_q;

	logic [8:0] tpos;
	logic [7:0] t;
	logic in_tcp;
	logic [6:0] area;
	logic [7:0] oi;
	logic [8:0] lenend;
	logic [8:0] need;
	logic ign;
	logic [IdxW-1:0] sidx;
	out_item_t out_d;

	assign tpos = {1'b0, pos_q} - 9'd14 - {3'b0, iphl_q};
	assign t = tpos[7:0];
	assign in_tcp = pos_q > 8'd14 && iphl_q >= 6'd20 && !tpos[8];
	assign area = tcphl_q - 7'd20;
	assign oi = t - 8'd20;
	assign lenend = {1'b0, oi} - 9'd1 + {1'b0, frame_byte};
	assign need = 9'd14 + {3'b0, iphl_q} + {2'b0, tcphl_q};
	assign sidx = sidx_q[IdxW-1:0];
	assign sts.search_done = ign_q || found_q || (sidx_q == CntW'(TableEntries));

	always_comb begin
		ign = pos_q < 8'd54 || ether_q != 16'h0800 || iphl_q < 6'd20 ||
			proto_q != 8'd6 || tcphl_q < 7'd20 || {1'b0, pos_q} < need ||
			!flags_q[1] || src_q == own_address;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; ether_q <= '0; iphl_q <= '0; proto_q <= '0;
			src_q <= '0; ttl_q <= '0; tcphl_q <= '0; flags_q <= '0;
			win_q <= '0; ph_q <= PH_KIND; kind_q <= '0; left_q <= '0;
			mss_q <= '0; scl_q <= '0; sack_q <= '0;
		end else if (cmd.commit) begin
			pos_q <= '0; ether_q <= '0; iphl_q <= '0; proto_q <= '0;
			src_q <= '0; ttl_q <= '0; tcphl_q <= '0; flags_q <= '0;
			win_q <= '0; ph_q <= PH_KIND; kind_q <= '0; left_q <= '0;
			mss_q <= '0; scl_q <= '0; sack_q <= '0;
		end else if (cmd.take_byte) begin
			case (pos_q)
				8'd12: ether_q[15:8] <= frame_byte;
				8'd13: ether_q[7:0] <= frame_byte;
				8'd14: iphl_q <= {frame_byte[3:0], 2'b00};
				8'd22: ttl_q <= frame_byte;
				8'd23: proto_q <= frame_byte;
				8'd26, 8'd27, 8'd28, 8'd29: src_q <= {src_q[23:0], frame_byte};
				default: ;
			endcase
			if (in_tcp) begin
				if (t == 8'd12) tcphl_q <= {1'b0, frame_byte[7:4], 2'b00};
				else if (t == 8'd13) flags_q <= frame_byte;
				else if (t == 8'd14) win_q[15:8] <= frame_byte;
				else if (t == 8'd15) win_q[7:0] <= frame_byte;
				else if (t >= 8'd20 && t < {1'b0, tcphl_q}) begin
					case (ph_q)
						PH_KIND: begin
							if (frame_byte == OPT_END) ph_q <= PH_DONE;
							else if (frame_byte != OPT_NOP) begin
								if ({1'b0, oi} + 9'd1 >= {2'b0, area}) ph_q <= PH_DONE;
								else begin
									kind_q <= frame_byte;
									ph_q <= PH_LEN;
								end
							end
						end
						PH_LEN: begin
							if (frame_byte < 8'd2 || lenend > {2'b0, area}) ph_q <= PH_DONE;
							else begin
								if (kind_q == OPT_SACK) sack_q <= 1'b1;
								if ((kind_q == OPT_MSS && frame_byte != 8'd4) ||
									(kind_q == OPT_SCALE && frame_byte != 8'd3))
									kind_q <= '0;
								left_q <= frame_byte - 8'd2;
								ph_q <= (frame_byte == 8'd2) ? PH_KIND : PH_BODY;
							end
						end
						PH_BODY: begin
							if (kind_q == OPT_MSS) begin
								if (left_q == 8'd2) mss_q <= {frame_byte, 8'h00};
								else mss_q[7:0] <= mss_q[7:0] | frame_byte;
							end else if (kind_q == OPT_SCALE) scl_q <= frame_byte;
							left_q <= left_q - 8'd1;
							if (left_q == 8'd1) ph_q <= PH_KIND;
						end
						default: ;
					endcase
				end
			end
			if (pos_q != 8'd255) pos_q <= pos_q + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sidx_q <= '0; found_q <= 1'b0; have_free_q <= 1'b0; ign_q <= 1'b0;
			slot_q <= '0; free_q <= '0;
		end else if (cmd.start_search) begin
			sidx_q <= '0; found_q <= 1'b0; have_free_q <= 1'b0; ign_q <= 1'b0;
		end else if (cmd.search_step) begin
			if (sidx_q == '0) ign_q <= ign;
			if (!(sidx_q == '0 && ign)) begin
				if (!valid_q[sidx]) begin
					if (!have_free_q) begin
						have_free_q <= 1'b1;
						free_q <= sidx;
					end
				end else if (addr_q[sidx] == src_q) begin
					found_q <= 1'b1;
					slot_q <= sidx;
				end
				if (!(valid_q[sidx] && addr_q[sidx] == src_q))
					sidx_q <= sidx_q + CntW'(1);
			end
		end
	end

	// frame fields are stable once the search runs
	always_ff @(posedge clk) begin
		if (cmd.search_step)
			cls_q <= guess_class(ttl_q, win_q, mss_q, scl_q, sack_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= '0;
		else if (cmd.commit && !ign_q && !found_q && have_free_q)
			valid_q[free_q] <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && !ign_q && !found_q && have_free_q)
			addr_q[free_q] <= src_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.load_out) out_valid <= 1'b1;
		else if (out_taken) out_valid <= 1'b0;
	end

	always_comb begin
		out_d = '0;
		if (ign_q) out_d.status = ST_IGNORED;
		else begin
			out_d.host_address = src_q;
			out_d.os_class = cls_q;
			out_d.seen_ttl = ttl_q;
			out_d.window_size = win_q;
			out_d.max_segment = mss_q;
			out_d.window_scale = scl_q;
			out_d.sack_permitted = sack_q;
			if (found_q) begin
				out_d.status = ST_RECORDED;
				out_d.entry_index = 3'(slot_q);
			end else if (have_free_q) begin
				out_d.status = ST_RECORDED;
				out_d.entry_index = 3'(free_q);
				out_d.new_entry = 1'b1;
			end else out_d.status = ST_FULL;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) out_item <= out_d;
	end

endmodule
`default_nettype wire

### src/tcp_syn_os_fingerprinter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_syn_os_fingerprinter_top
// passive tcp syn os fingerprinter with an 8-entry host table
// ----------------------------------------------------------------------------
// one frame beat per cycle while streaming
// after the last beat: table search, one entry per cycle, until a match, an
// ignored frame or the table end; then the result register is loaded once free
// input ready drops from the last beat until the result is loaded
// reset clears the table valid bits and all frame state; own_address to zero
module tcp_syn_os_fingerprinter_top
	import tsof_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data,
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	input  wire logic [31:0] cfg_data
);

	logic [31:0] own_q;
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic in_fire, out_free;

	assign cfg_ready = 1'b1;
	assign in_fire = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) own_q <= '0;
		else if (cfg_valid) own_q <= cfg_data;
	end

	tsof_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.in_last(in_data.last_byte), .out_free(out_free), .sts(sts),
		.cmd(cmd), .in_ready(in_ready)
	);

	tsof_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .frame_byte(in_data.frame_byte),
		.own_address(own_q), .out_taken(out_ready), .sts(sts),
		.out_item(out_data), .out_valid(out_valid)
	);

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || out_ready))
		else $error("result loaded over a pending beat");
	a_no_take_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.search_step |-> !in_ready)
		else $error("input ready during table search");
	a_last_starts_search: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_data.last_byte) |=> !in_ready)
		else $error("input taken right after last beat");

endmodule
`default_nettype wire

### verif/tcp_syn_os_fingerprinter_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_syn_os_fingerprinter_top_test
// streams ethernet frames into the syn fingerprinter and checks each frame
// result against a byte-level predictor of the parser, host table and os guess
// ----------------------------------------------------------------------------
module tcp_syn_os_fingerprinter_top_test;
	import tsof_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [31:0] cfg_data = '0;

	tcp_syn_os_fingerprinter_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	logic [31:0] p_own;
	int unsigned p_pos, p_ether, p_iphl, p_proto, p_src, p_ttl, p_tcphl;
	int unsigned p_flags, p_win, p_okind, p_oleft, p_mss, p_scale, p_sack;
	logic [1:0] p_phase;
	logic p_valid [TableEntries];
	logic [31:0] p_addr [TableEntries];

	out_item_t expected_results[$];
	int fail_count = 0;
	bit idle_on = 1'b1;
	int rx_hold = 0;
	logic [7:0] frame_buf[$];

	task automatic clear_frame_state();
		p_pos = 0; p_ether = 0; p_iphl = 0; p_proto = 0; p_src = 0; p_ttl = 0;
		p_tcphl = 0; p_flags = 0; p_win = 0; p_phase = PH_KIND; p_okind = 0;
		p_oleft = 0; p_mss = 0; p_scale = 0; p_sack = 0;
	endtask

	function automatic logic [3:0] os_guess();
		if (p_ttl > 128) return 4'd8;
		if (p_ttl > 64) begin
			if (p_win == 65535 || p_win == 8192) return 4'd0;
			if (p_win == 64240) return 4'd1;
			return 4'd2;
		end
		if (p_mss == 1460 && (p_scale == 6 || p_scale == 7)) return 4'd3;
		if (p_mss == 1460 && p_sack != 0) return 4'd4;
		if (p_mss == 1460) return 4'd5;
		if (p_mss == 536) return 4'd6;
		return 4'd7;
	endfunction

	task automatic walk_option(input int unsigned b, input int unsigned i,
		input int unsigned area);
		if (p_phase == PH_KIND) begin
			if (b == OPT_END) p_phase = PH_DONE;
			else if (b == OPT_NOP) ;
			else if (i + 1 >= area) p_phase = PH_DONE;
			else begin
				p_okind = b;
				p_phase = PH_LEN;
			end
		end else if (p_phase == PH_LEN) begin
			if (b < 2 || (i - 1) + b > area) p_phase = PH_DONE;
			else begin
				if (p_okind == OPT_SACK) p_sack = 1;
				if (p_okind == OPT_MSS && b != 4) p_okind = 0;
				if (p_okind == OPT_SCALE && b != 3) p_okind = 0;
				p_oleft = b - 2;
				p_phase = (p_oleft != 0) ? PH_BODY : PH_KIND;
			end
		end else if (p_phase == PH_BODY) begin
			if (p_okind == OPT_MSS) begin
				if (p_oleft == 2) p_mss = b << 8;
				else p_mss = p_mss | b;
			end else if (p_okind == OPT_SCALE) p_scale = b;
			p_oleft--;
			if (p_oleft == 0) p_phase = PH_KIND;
		end
	endtask

	task automatic predict_beat(input in_item_t it);
		int unsigned b, t, pos;
		out_item_t r;
		bit found, have_free;
		int slot, free_slot;
		b = 32'(it.frame_byte);
		pos = p_pos;
		if (pos == 12) p_ether = b << 8;
		else if (pos == 13) p_ether = p_ether | b;
		else if (pos == 14) p_iphl = (b & 'h0F) * 4;
		else if (pos == 22) p_ttl = b;
		else if (pos == 23) p_proto = b;
		else if (pos >= 26 && pos <= 29) p_src = (p_src << 8) | b;
		if (pos > 14 && p_iphl >= 20 && pos >= 14 + p_iphl) begin
			t = pos - 14 - p_iphl;
			if (t == 12) p_tcphl = ((b >> 4) & 'h0F) * 4;
			else if (t == 13) p_flags = b;
			else if (t == 14) p_win = b << 8;
			else if (t == 15) p_win = p_win | b;
			else if (t >= 20 && t < p_tcphl) walk_option(b, t - 20, p_tcphl - 20);
		end
		if (p_pos < 255) p_pos++;
		if (!it.last_byte) return;
		r = '0;
		r.status = ST_IGNORED;
		if (!(p_pos < 54 || p_ether != 'h0800 || p_iphl < 20 || p_proto != 6 ||
			p_tcphl < 20 || p_pos < 14 + p_iphl + p_tcphl || (p_flags & 2) == 0 ||
			p_src[31:0] == p_own)) begin
			found = 0; have_free = 0; slot = 0; free_slot = 0;
			for (int k = 0; k < TableEntries; k++) begin
				if (!p_valid[k]) begin
					if (!have_free) begin
						have_free = 1;
						free_slot = k;
					end
				end else if (!found && p_addr[k] == p_src[31:0]) begin
					found = 1;
					slot = k;
				end
			end
			r.host_address = p_src;
			r.os_class = os_guess();
			r.seen_ttl = 8'(p_ttl);
			r.window_size = 16'(p_win);
			r.max_segment = 16'(p_mss);
			r.window_scale = 8'(p_scale);
			r.sack_permitted = p_sack[0];
			if (!found && !have_free) r.status = ST_FULL;
			else begin
				if (!found) begin
					slot = free_slot;
					p_valid[slot] = 1'b1;
					p_addr[slot] = p_src;
					r.new_entry = 1'b1;
				end
				r.status = ST_RECORDED;
				r.entry_index = slot[2:0];
			end
		end
		expected_results.push_back(r);
		clear_frame_state();
	endtask

	// result checker and receiver stall
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result beat %p", out_data);
				fail_count++;
			end else begin
				out_item_t e;
				e = expected_results.pop_front();
				if (out_data.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, out_data.status); fail_count++;
				end
				if (out_data.host_address !== e.host_address) begin
					$error("host_address exp %h got %h", e.host_address, out_data.host_address);
					fail_count++;
				end
				if (out_data.entry_index !== e.entry_index) begin
					$error("entry_index exp %0d got %0d", e.entry_index, out_data.entry_index);
					fail_count++;
				end
				if (out_data.new_entry !== e.new_entry) begin
					$error("new_entry exp %0d got %0d", e.new_entry, out_data.new_entry);
					fail_count++;
				end
				if (out_data.os_class !== e.os_class) begin
					$error("os_class exp %0d got %0d", e.os_class, out_data.os_class);
					fail_count++;
				end
				if (out_data.seen_ttl !== e.seen_ttl) begin
					$error("seen_ttl exp %0d got %0d", e.seen_ttl, out_data.seen_ttl);
					fail_count++;
				end
				if (out_data.window_size !== e.window_size) begin
					$error("window_size exp %0d got %0d", e.window_size, out_data.window_size);
					fail_count++;
				end
				if (out_data.max_segment !== e.max_segment) begin
					$error("max_segment exp %0d got %0d", e.max_segment, out_data.max_segment);
					fail_count++;
				end
				if (out_data.window_scale !== e.window_scale) begin
					$error("window_scale exp %0d got %0d", e.window_scale,
						out_data.window_scale);
					fail_count++;
				end
				if (out_data.sack_permitted !== e.sack_permitted) begin
					$error("sack_permitted exp %0d got %0d", e.sack_permitted,
						out_data.sack_permitted);
					fail_count++;
				end
			end
		end
	end

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
				rx_hold--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 16);
				out_ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else out_ready <= 1'b1;
		end
	end

	// valid stays high after the beat; the next beat or drain replaces it
	task automatic send_beat(input logic [7:0] b, input logic last);
		in_item_t it;
		if (idle_on && $urandom_range(0, 19) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		it.frame_byte = b;
		it.last_byte = last;
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_beat(it);
		@(negedge clk);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_buf.size(); i++)
			send_beat(frame_buf[i], i == frame_buf.size() - 1);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_own_address(input logic [31:0] a);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= a;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		p_own = a;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// builds a syn frame; opts holds the tcp option bytes
	task automatic build_syn(input logic [31:0] src, input logic [7:0] ttl,
		input logic [15:0] win, input logic [7:0] flags, input logic [7:0] opts[$],
		input int pad);
		int ol;
		ol = (opts.size() + 3) / 4 * 4;
		frame_buf.delete();
		for (int i = 0; i < 12; i++) frame_buf.push_back(8'($urandom));
		frame_buf.push_back(8'h08); frame_buf.push_back(8'h00);
		frame_buf.push_back(8'h45);
		for (int i = 15; i < 22; i++) frame_buf.push_back(8'($urandom));
		frame_buf.push_back(ttl); frame_buf.push_back(8'd6);
		frame_buf.push_back(8'($urandom)); frame_buf.push_back(8'($urandom));
		for (int i = 3; i >= 0; i--) frame_buf.push_back(src[i*8 +: 8]);
		for (int i = 0; i < 4; i++) frame_buf.push_back(8'($urandom));
		for (int i = 0; i < 12; i++) frame_buf.push_back(8'($urandom));
		frame_buf.push_back(8'((5 + ol / 4) << 4) | 8'($urandom_range(0, 15)));
		frame_buf.push_back(flags);
		frame_buf.push_back(win[15:8]); frame_buf.push_back(win[7:0]);
		for (int i = 0; i < 4; i++) frame_buf.push_back(8'($urandom));
		for (int i = 0; i < ol; i++) frame_buf.push_back(i < opts.size() ? opts[i] : 8'd0);
		for (int i = 0; i < pad; i++) frame_buf.push_back(8'($urandom));
	endtask

	function automatic logic [31:0] pick_host();
		case ($urandom_range(0, 3))
			0: return 32'hC0A8_0000 | $urandom_range(0, 11);
			1: return $urandom;
			2: return 32'hFFFF_FFFF;
			default: return 32'h0A00_0000 | $urandom_range(0, 5);
		endcase
	endfunction

	function automatic logic [7:0] pick_ttl();
		case ($urandom_range(0, 4))
			0: return 8'd64;
			1: return 8'd128;
			2: return 8'd255;
			3: return 8'd65;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_win();
		case ($urandom_range(0, 4))
			0: return 16'd65535;
			1: return 16'd8192;
			2: return 16'd64240;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_options(output logic [7:0] o[$]);
		o.delete();
		repeat ($urandom_range(0, 5)) begin
			case ($urandom_range(0, 7))
				0: begin o.push_back(OPT_MSS); o.push_back(8'd4);
					o.push_back($urandom_range(0, 1) ? 8'h05 : 8'h02);
					o.push_back($urandom_range(0, 1) ? 8'hB4 : 8'h18); end
				1: begin o.push_back(OPT_SCALE); o.push_back(8'd3);
					o.push_back(8'($urandom_range(0, 9))); end
				2: begin o.push_back(OPT_SACK); o.push_back(8'd2); end
				3: o.push_back(OPT_NOP);
				4: begin o.push_back(8'd8); o.push_back(8'd10);
					repeat (8) o.push_back(8'($urandom)); end
				5: if ($urandom_range(0, 3) == 0) o.push_back(OPT_END);
				6: begin o.push_back(8'($urandom)); o.push_back(8'($urandom)); end
				default: begin o.push_back(OPT_MSS); o.push_back(8'($urandom_range(0, 6)));
					o.push_back(8'($urandom)); end
			endcase
		end
		if (o.size() > 40) o = o[0:39];
	endtask

	task automatic test_directed();
		logic [7:0] o[$];
		o = '{OPT_MSS, 8'd4, 8'h05, 8'hB4, OPT_NOP, OPT_SCALE, 8'd3, 8'd7};
		build_syn(32'hC0A8_0001, 8'd64, 16'd29200, 8'h02, o, 0); send_frame();
		o = '{OPT_MSS, 8'd4, 8'h05, 8'hB4, OPT_SACK, 8'd2};
		build_syn(32'hC0A8_0002, 8'd64, 16'd100, 8'h12, o, 0); send_frame();
		o = '{OPT_MSS, 8'd4, 8'h05, 8'hB4};
		build_syn(32'hC0A8_0003, 8'd60, 16'd1, 8'hFF, o, 4); send_frame();
		o = '{};
		build_syn(32'h0000_0000, 8'd0, 16'd0, 8'h02, o, 0); send_frame();
		build_syn(32'hFFFF_FFFF, 8'd255, 16'hFFFF, 8'h02, o, 0); send_frame();
		build_syn(32'h0A00_0001, 8'd128, 16'd65535, 8'h02, o, 0); send_frame();
		build_syn(32'h0A00_0002, 8'd100, 16'd8192, 8'h02, o, 0); send_frame();
		build_syn(32'h0A00_0003, 8'd129, 16'd64240, 8'h02, o, 0); send_frame();
		build_syn(32'h0A00_0004, 8'd65, 16'd64240, 8'h02, o, 0); send_frame();
		build_syn(32'h0A00_0005, 8'd80, 16'd5, 8'h02, o, 0); send_frame();
		// table now full: new host gets table full, known host still matches
		build_syn(32'h0A00_0006, 8'd64, 16'd5, 8'h02, o, 0); send_frame();
		build_syn(32'h0A00_0001, 8'd64, 16'd5, 8'h02, o, 0); send_frame();
		// no syn flag
		build_syn(32'h0B00_0001, 8'd64, 16'd5, 8'hFD, o, 0); send_frame();
		// truncated inside the options
		o = '{OPT_MSS, 8'd4, 8'h05, 8'hB4, OPT_SACK, 8'd2, OPT_NOP, OPT_NOP};
		build_syn(32'h0B00_0002, 8'd64, 16'd5, 8'h02, o, 0);
		frame_buf.pop_back(); send_frame();
		// malformed options: runs past area, length below 2, repeated mss
		o = '{OPT_MSS, 8'd4, 8'h01, 8'h00, OPT_MSS, 8'd4, 8'h05, 8'hB4, OPT_SCALE, 8'd9};
		build_syn(32'h0A00_0001, 8'd64, 16'd5, 8'h02, o, 0); send_frame();
		o = '{OPT_SCALE, 8'd3, 8'd6, OPT_MSS, 8'd1, 8'h05, 8'hB4, 8'd0};
		build_syn(32'h0A00_0002, 8'd64, 16'd5, 8'h02, o, 0); send_frame();
		o = '{OPT_NOP, OPT_NOP, OPT_NOP, OPT_MSS};
		build_syn(32'h0A00_0003, 8'd64, 16'd5, 8'h02, o, 0); send_frame();
		// short ip header, wrong ethertype, short frame, long frame
		o = '{};
		build_syn(32'h0A00_0004, 8'd64, 16'd5, 8'h02, o, 0);
		frame_buf[14] = 8'h44; send_frame();
		build_syn(32'h0A00_0004, 8'd64, 16'd5, 8'h02, o, 0);
		frame_buf[12] = 8'h86; send_frame();
		frame_buf.delete();
		for (int i = 0; i < 20; i++) frame_buf.push_back(8'($urandom));
		send_frame();
		build_syn(32'h0A00_0005, 8'd64, 16'd5, 8'h02, o, 202); send_frame();
		// one-byte frame
		send_beat(8'hA5, 1'b1);
	endtask

	task automatic test_own_address();
		logic [7:0] o[$];
		o = '{};
		write_own_address(32'h0A00_0001);
		build_syn(32'h0A00_0001, 8'd64, 16'd5, 8'h02, o, 0); send_frame();
		write_own_address(32'hFFFF_FFFF);
		build_syn(32'hFFFF_FFFF, 8'd64, 16'd5, 8'h02, o, 0); send_frame();
		build_syn(32'h0000_0000, 8'd64, 16'd5, 8'h02, o, 0); send_frame();
	endtask

	task automatic random_frame();
		logic [7:0] o[$];
		int k;
		k = $urandom_range(0, 9);
		random_options(o);
		build_syn(pick_host(), pick_ttl(), pick_win(),
			k == 0 ? 8'($urandom) : 8'($urandom) | 8'h02, o, $urandom_range(0, 3));
		if (k == 1) frame_buf[$urandom_range(0, frame_buf.size() - 1)] = 8'($urandom);
		if (k == 2) frame_buf = frame_buf[0:$urandom_range(0, frame_buf.size() - 1)];
		if (k == 3) frame_buf[46] = 8'($urandom);
		send_frame();
	endtask

	task automatic test_random_frames(input int n);
		for (int k = 0; k < n; k++) random_frame();
	endtask

	task automatic test_backpressure();
		rx_hold = 200;
		for (int n = 0; n < 2; n++) random_frame();
		drain();
		random_frame();
	endtask

	initial begin
		p_own = '0;
		for (int k = 0; k < TableEntries; k++) begin
			p_valid[k] = 1'b0;
			p_addr[k] = '0;
		end
		clear_frame_state();
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_own_address();
		write_own_address($urandom);
		test_random_frames(2);
		test_backpressure();
		write_own_address(32'h0000_0000);
		idle_on = 1'b0;
		test_random_frames(2);
		drain();
		if (fail_count == 0)
			$display("tcp_syn_os_fingerprinter_top: match");
		else
			$display("tcp_syn_os_fingerprinter_top: mismatch");
		$finish;
	end

	initial begin
		#20ms;
		$display("tcp_syn_os_fingerprinter_top: mismatch");
		$finish;
	end

endmodule
